>>> src/ssm_pkg.sv
package ssm_pkg;

   localparam int MAX_PATTERN_DEFAULT = 16;
   localparam int POS_W = 32;
   localparam int BYTE_W = 8;
   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 4;

   typedef enum logic [0:0] {
      KIND_PATTERN = 1'b0,
      KIND_TEXT    = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic              restart;
      logic [BYTE_W-1:0] byte_value;
      logic [POS_W-1:0]  index;
   } cmd_type;

endpackage

>>> src/ssm_fifo.sv
module ssm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] data_in,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] data_out,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

>>> src/ssm_front.sv
module ssm_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic                        req_action,
   input  logic [ssm_pkg::BYTE_W-1:0]  req_byte_value,
   input  logic                        req_first,
   output logic                        cmd_push,
   output ssm_pkg::cmd_type            cmd_data,
   input  logic                        cmd_full
);

   logic [ssm_pkg::POS_W-1:0] position_ff, position_in;
   logic [ssm_pkg::POS_W-1:0] index;
   logic                      accept;
   ssm_pkg::kind_type         kind;

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;
   assign cmd_push = accept;
   assign kind     = req_action ? ssm_pkg::KIND_TEXT : ssm_pkg::KIND_PATTERN;

   // text index of this word, restarting on a new text
   assign index = req_first ? '0 : position_ff;

   always_comb begin
      position_in = position_ff;
      if (accept && kind == ssm_pkg::KIND_TEXT) begin
         position_in = (index != '1) ? index + 1'b1 : index;
      end
   end

   always_comb begin
      cmd_data.kind       = kind;
      cmd_data.restart    = req_first;
      cmd_data.byte_value = req_byte_value;
      cmd_data.index      = index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
      end else begin
         position_ff <= position_in;
      end
   end

endmodule

>>> src/ssm_back.sv
module ssm_back #(
   parameter int MAX_PATTERN = ssm_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ssm_pkg::cmd_type            cmd_data,
   input  logic                        cmd_empty,
   output logic                        cmd_pop,
   output logic                        rsp_push,
   output logic [ssm_pkg::POS_W-1:0]   rsp_data,
   input  logic                        rsp_full
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [ssm_pkg::BYTE_W-1:0] pattern_ff [MAX_PATTERN];
   logic [ssm_pkg::BYTE_W-1:0] window_ff  [MAX_PATTERN];
   logic [ssm_pkg::BYTE_W-1:0] window_in  [MAX_PATTERN];
   logic [LEN_W-1:0]           length_ff, length_in, length_base;
   logic [LEN_W-1:0]           fill_ff, fill_in, fill_base;
   logic                       is_text, take, hit;

   assign take    = !cmd_empty && !rsp_full;
   assign cmd_pop = take;
   assign is_text = (cmd_data.kind == ssm_pkg::KIND_TEXT);

   assign length_base = cmd_data.restart ? '0 : length_ff;
   assign fill_base   = cmd_data.restart ? '0 : fill_ff;

   always_comb begin
      length_in = length_ff;
      fill_in   = fill_ff;
      if (take && !is_text && length_base < LEN_W'(MAX_PATTERN)) begin
         length_in = length_base + 1'b1;
      end else if (take && !is_text) begin
         length_in = length_base;
      end
      if (take && is_text) begin
         fill_in = (fill_base < LEN_W'(MAX_PATTERN)) ? fill_base + 1'b1 : fill_base;
      end
   end

   // window entry 0 holds the newest text byte
   always_comb begin
      window_in[0] = cmd_data.byte_value;
      for (int j = 1; j < MAX_PATTERN; j++) begin
         window_in[j] = window_ff[j-1];
      end
   end

   // pattern byte k lines up with the byte length-1-k words back
   always_comb begin
      logic [LEN_W-1:0] offset;
      hit = (length_ff != '0) && (fill_in >= length_ff);
      for (int k = 0; k < MAX_PATTERN; k++) begin
         offset = length_ff - LEN_W'(k + 1);
         if (LEN_W'(k) < length_ff) begin
            if (pattern_ff[k] != window_in[offset[IDX_W-1:0]]) begin
               hit = 1'b0;
            end
         end
      end
   end

   assign rsp_push = take && is_text && hit;
   assign rsp_data = cmd_data.index - ssm_pkg::POS_W'(length_ff) + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         fill_ff   <= '0;
      end else begin
         length_ff <= length_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && !is_text && length_base < LEN_W'(MAX_PATTERN)) begin
         pattern_ff[length_base[IDX_W-1:0]] <= cmd_data.byte_value;
      end
      if (take && is_text) begin
         window_ff <= window_in;
      end
   end

endmodule

>>> src/substring_match_stream_core.sv
// Exact substring search over a byte stream. Pattern words (action 0) are stored, up to
// MAX_PATTERN bytes, with first starting a new pattern; text words (action 1) shift into a
// window, with first starting a new text at index 0. Each text word that completes a window
// equal to the whole pattern yields one result word holding the zero-based start index of
// that occurrence; an empty pattern never matches and the text index saturates at all ones.
// One word is taken per clock cycle, sustained, as long as results are popped; a result
// is on the result ports once its text word has left the command queue and the back end
// has pushed it into the result queue, and can then be popped; the parallel compare of the
// pattern against the window in the back end finishes in the cycle that takes the word, and
// the command queue and result queue let the input and output sides stall independently.
module substring_match_stream_core #(
   parameter int MAX_PATTERN = ssm_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  logic                        req_action,
   input  logic [ssm_pkg::BYTE_W-1:0]  req_byte_value,
   input  logic                        req_first,
   output logic                        empty,
   input  logic                        pop,
   output logic [ssm_pkg::POS_W-1:0]   rsp_match_start
);

   localparam int CMD_W = $bits(ssm_pkg::cmd_type);

   ssm_pkg::cmd_type          front_cmd, back_cmd;
   logic                      cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic [CMD_W-1:0]          cmd_out;
   logic                      rsp_push, rsp_full;
   logic [ssm_pkg::POS_W-1:0] rsp_data;

   ssm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (push),
      .req_full       (full),
      .req_action     (req_action),
      .req_byte_value (req_byte_value),
      .req_first      (req_first),
      .cmd_push       (cmd_push),
      .cmd_data       (front_cmd),
      .cmd_full       (cmd_full)
   );

   ssm_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (ssm_pkg::CMD_DEPTH)
   ) u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .data_in  (front_cmd),
      .full     (cmd_full),
      .pop      (cmd_pop),
      .data_out (cmd_out),
      .empty    (cmd_empty)
   );

   assign back_cmd = ssm_pkg::cmd_type'(cmd_out);

   ssm_back #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (back_cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_data),
      .rsp_full  (rsp_full)
   );

   ssm_fifo #(
      .WIDTH (ssm_pkg::POS_W),
      .DEPTH (ssm_pkg::RSP_DEPTH)
   ) u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (rsp_push),
      .data_in  (rsp_data),
      .full     (rsp_full),
      .pop      (pop),
      .data_out (rsp_match_start),
      .empty    (empty)
   );

endmodule
